[rtl/core/fcschk_pkg.sv]
// shared types, constants and the byte-wide crc-32 update for the fcs checker
package fcschk_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CRC_W   = 32;
    localparam int unsigned FCS_LEN = 4;
    localparam int unsigned SEEN_W  = 3;

    localparam logic [CRC_W-1:0]  CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY = 32'hEDB8_8320;
    localparam logic [SEEN_W-1:0] SEEN_FULL = SEEN_W'(FCS_LEN);

    typedef enum logic
    {
        MODE_COMPUTE  = 1'b0,
        MODE_VALIDATE = 1'b1
    } check_mode_t;

    typedef struct packed
    {
        logic [BYTE_W-1:0] data_byte;
        logic              frame_end;
    } fcs_item_t;

    typedef struct packed
    {
        logic [CRC_W-1:0] crc_value;
        logic             fcs_ok;
        logic             too_short;
    } fcs_result_t;

    // reflected crc-32, one byte, lsb first
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc_in ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[rtl/core/fcschk_in_stage.sv]
// input register for the byte stream
module fcschk_in_stage
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // data_byte
    input  logic                  s_axis_tlast,   // frame_end
    input  logic                  take,
    output logic                  item_valid,
    output fcschk_pkg::fcs_item_t item
);
    import fcschk_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    fcs_item_t item_reg;
    logic      accept;

    assign s_axis_tready = !valid_reg || take;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign item_valid    = valid_reg;
    assign item          = item_reg;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.data_byte <= s_axis_tdata;
            item_reg.frame_end <= s_axis_tlast;
        end
    end

endmodule

[rtl/core/fcschk_engine.sv]
// crc accumulator, fcs delay line and frame result logic
module fcschk_engine
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic                    cfg_mode,
    input  logic                    fire,
    input  fcschk_pkg::fcs_item_t   item,
    output logic                    res_valid,
    output fcschk_pkg::fcs_result_t res
);
    import fcschk_pkg::*;

    check_mode_t       mode_reg;
    logic [CRC_W-1:0]  crc_reg;
    logic [CRC_W-1:0]  crc_next;
    logic [SEEN_W-1:0] seen_reg;
    logic [SEEN_W-1:0] seen_next;
    logic [BYTE_W-1:0] tail_reg [FCS_LEN];

    logic [CRC_W-1:0]  crc_upd;
    logic [SEEN_W-1:0] seen_upd;
    logic [CRC_W-1:0]  calc;
    logic [CRC_W-1:0]  rcvd;

    always_comb
    begin
        res_valid     = fire && item.frame_end;
        res.crc_value = '0;
        res.fcs_ok    = 1'b0;
        res.too_short = 1'b0;
        seen_upd      = (seen_reg < SEEN_FULL) ? seen_reg + SEEN_W'(1) : seen_reg;
        rcvd          = {item.data_byte, tail_reg[3], tail_reg[2], tail_reg[1]};
        unique case (mode_reg)
            MODE_COMPUTE:
            begin
                crc_upd = crc_byte(crc_reg, item.data_byte);
            end
            MODE_VALIDATE:
            begin
                crc_upd = (seen_reg == SEEN_FULL) ? crc_byte(crc_reg, tail_reg[0]) : crc_reg;
            end
            default:
            begin
                crc_upd = crc_reg;
            end
        endcase
        calc = crc_upd ^ CRC_INIT;
        if (mode_reg == MODE_COMPUTE)
        begin
            res.crc_value = calc;
        end
        else if (seen_upd < SEEN_FULL)
        begin
            res.too_short = 1'b1;
        end
        else
        begin
            res.crc_value = calc;
            res.fcs_ok    = (calc == rcvd);
        end

        crc_next  = crc_reg;
        seen_next = seen_reg;
        priority if (cfg_wr_en || res_valid)
        begin
            crc_next  = CRC_INIT;
            seen_next = '0;
        end
        else if (fire)
        begin
            crc_next  = crc_upd;
            seen_next = (mode_reg == MODE_VALIDATE) ? seen_upd : '0;
        end
        else
        begin
            crc_next  = crc_reg;
            seen_next = seen_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_VALIDATE;
            crc_reg  <= CRC_INIT;
            seen_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= check_mode_t'(cfg_mode);
            end
            crc_reg  <= crc_next;
            seen_reg <= seen_next;
        end
    end

    // delay line, entry 0 oldest
    always_ff @(posedge clk)
    begin
        if (fire && mode_reg == MODE_VALIDATE)
        begin
            tail_reg[0] <= tail_reg[1];
            tail_reg[1] <= tail_reg[2];
            tail_reg[2] <= tail_reg[3];
            tail_reg[3] <= item.data_byte;
        end
    end

`ifndef SYNTHESIS
    a_seen_sat: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= SEEN_FULL)
        else $error("byte count above fcs length");
    a_compute_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_COMPUTE |-> seen_reg == '0)
        else $error("byte count moved in compute mode");
    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> crc_reg == CRC_INIT && seen_reg == '0)
        else $error("register write did not clear frame state");
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> crc_reg == CRC_INIT && seen_reg == '0)
        else $error("frame end did not clear frame state");
    a_short_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.too_short |-> !res.fcs_ok && res.crc_value == '0)
        else $error("short frame result not cleared");
`endif

endmodule

[rtl/core/fcschk_out_stage.sv]
// result register towards the master side
module fcschk_out_stage
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load,
    input  fcschk_pkg::fcs_result_t res,
    output logic                    space,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [31:0]             m_axis_tdata,   // crc_value
    output logic [1:0]              m_axis_tuser    // fcs_ok, too_short
);
    import fcschk_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    fcs_result_t res_reg;

    assign space         = !valid_reg || m_axis_tready;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = res_reg.crc_value;
    assign m_axis_tuser  = {res_reg.too_short, res_reg.fcs_ok};

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule

[rtl/core/wifi_fcs_crc32_checker.sv]
// top level of the 802.11 fcs crc-32 checker
// throughput: one byte per cycle, set by the byte-wide crc update, while the result register has room for a last byte
// a frame result is registered: its last byte passes the input register, then the result
// register, and waits in the input register while the result register is full
// reset: rst_n async active low; empties both registers, mode to validate,
// crc to all ones, byte count to zero; a register write also clears the frame
module wifi_fcs_crc32_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        check_mode,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data_byte
    input  logic        s_axis_tlast,   // frame_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // crc_value
    output logic [1:0]  m_axis_tuser    // fcs_ok, too_short
);
    import fcschk_pkg::*;

    logic        item_valid;
    fcs_item_t   item;
    logic        fire;
    logic        space;
    logic        res_valid;
    fcs_result_t res;

    // a last byte waits for room in the result register
    assign fire = item_valid && (!item.frame_end || space);

    fcschk_in_stage u_in
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .take          (fire),
        .item_valid    (item_valid),
        .item          (item)
    );

    fcschk_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_mode  (check_mode),
        .fire      (fire),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    fcschk_out_stage u_out
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (res_valid),
        .res           (res),
        .space         (space),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

[dv/testbench.sv]
// self-checking testbench for the fcs crc-32 checker: directed frames, then random phases
module testbench;
    import fcschk_pkg::*;

    localparam int unsigned DRAIN_CYCLES = 4;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned RANDOM_ITEMS = 700;
    localparam int unsigned MAX_REPORTS  = 10;
    localparam int unsigned NUM_ROWS     = 26;

    typedef struct packed
    {
        logic        is_cfg;
        check_mode_t cfg_mode;
        logic [7:0]  data_byte;
        logic        frame_end;
        logic        typed;
        fcs_result_t want;
    } stim_row_t;

    localparam stim_row_t DIRECTED [NUM_ROWS] = '{
        // too short frames in validate mode, straight after reset
        '{1'b0, MODE_VALIDATE, 8'hAB, 1'b1, 1'b1, '{32'h0000_0000, 1'b0, 1'b1}},
        '{1'b0, MODE_VALIDATE, 8'h00, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
        '{1'b0, MODE_VALIDATE, 8'hFF, 1'b1, 1'b1, '{32'h0000_0000, 1'b0, 1'b1}},
        '{1'b0, MODE_VALIDATE, 8'h01, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
        '{1'b0, MODE_VALIDATE, 8'h80, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
        '{1'b0, MODE_VALIDATE, 8'h7F, 1'b1, 1'b1, '{32'h0000_0000, 1'b0, 1'b1}},
        // empty payload, fcs all zeros then all ones
        '{1'b0, MODE_VALIDATE, 8'h00, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
        '{1'b0, MODE_VALIDATE, 8'h00, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
        '{1'b0, MODE_VALIDATE, 8'h00, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
        '{1'b0, MODE_VALIDATE, 8'h00, 1'b1, 1'b1, '{32'h0000_0000, 1'b1, 1'b0}},
        '{1'b0, MODE_VALIDATE, 8'hFF, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
        '{1'b0, MODE_VALIDATE, 8'hFF, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
        '{1'b0, MODE_VALIDATE, 8'hFF, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
        '{1'b0, MODE_VALIDATE, 8'hFF, 1'b1, 1'b1, '{32'h0000_0000, 1'b0, 1'b0}},
        // one zero byte with its correct fcs
        '{1'b0, MODE_VALIDATE, 8'h00, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
        '{1'b0, MODE_VALIDATE, 8'h8D, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
        '{1'b0, MODE_VALIDATE, 8'hEF, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
        '{1'b0, MODE_VALIDATE, 8'h02, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
        '{1'b0, MODE_VALIDATE, 8'hD2, 1'b1, 1'b1, '{32'hD202_EF8D, 1'b1, 1'b0}},
        // compute mode, single byte frames
        '{1'b1, MODE_COMPUTE,  8'h00, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
        '{1'b0, MODE_COMPUTE,  8'h00, 1'b1, 1'b1, '{32'hD202_EF8D, 1'b0, 1'b0}},
        '{1'b0, MODE_COMPUTE,  8'hFF, 1'b1, 1'b1, '{32'hFF00_0000, 1'b0, 1'b0}},
        // open frame abandoned by a register write
        '{1'b0, MODE_COMPUTE,  8'h5A, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
        '{1'b0, MODE_COMPUTE,  8'hA5, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
        '{1'b1, MODE_COMPUTE,  8'h00, 1'b0, 1'b0, '{32'h0000_0000, 1'b0, 1'b0}},
        '{1'b0, MODE_COMPUTE,  8'h00, 1'b1, 1'b1, '{32'hD202_EF8D, 1'b0, 1'b0}}
    };

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic        check_mode    = MODE_VALIDATE;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    check_mode_t  mode_shadow = MODE_VALIDATE;
    logic [31:0]  running_crc = CRC_INIT;
    logic [7:0]   fcs_window [4];
    int unsigned  window_fill = 0;
    fcs_result_t  pending_results [$];
    logic [7:0]   frame_buf [$];
    int unsigned  mismatch_count = 0;
    int unsigned  items_sent = 0;
    bit           hold_req = 1'b0;

    wifi_fcs_crc32_checker uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .check_mode    (check_mode),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // data_byte
        .s_axis_tlast  (s_axis_tlast),   // frame_end
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // crc_value
        .m_axis_tuser  (m_axis_tuser)    // fcs_ok, too_short
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    // reflected crc-32, one data bit at a time
    function automatic logic [31:0] crc32_fold(input logic [31:0] c, input logic [7:0] d);
        logic [31:0] r;
        logic        fb;
        int          i;
        r = c;
        for (i = 0; i < 8; i++)
        begin
            fb = r[0] ^ d[i];
            r  = r >> 1;
            if (fb)
            begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    function automatic void restart_frame();
        running_crc = CRC_INIT;
        fcs_window  = '{8'h00, 8'h00, 8'h00, 8'h00};
        window_fill = 0;
    endfunction

    function automatic bit fcs_model_byte(input logic [7:0] d, input logic last,
                                          output fcs_result_t res);
        logic [31:0] calc;
        logic [31:0] rcvd;
        res = '0;
        if (mode_shadow == MODE_COMPUTE)
        begin
            running_crc = crc32_fold(running_crc, d);
            if (!last)
            begin
                return 1'b0;
            end
            res.crc_value = running_crc ^ CRC_INIT;
        end
        else
        begin
            // oldest held byte leaves the fcs window into the crc
            if (window_fill >= FCS_LEN)
            begin
                running_crc = crc32_fold(running_crc, fcs_window[0]);
            end
            fcs_window[0] = fcs_window[1];
            fcs_window[1] = fcs_window[2];
            fcs_window[2] = fcs_window[3];
            fcs_window[3] = d;
            if (window_fill < FCS_LEN)
            begin
                window_fill++;
            end
            if (!last)
            begin
                return 1'b0;
            end
            if (window_fill < FCS_LEN)
            begin
                res.too_short = 1'b1;
            end
            else
            begin
                calc = running_crc ^ CRC_INIT;
                rcvd = {fcs_window[3], fcs_window[2], fcs_window[1], fcs_window[0]};
                res.crc_value = calc;
                res.fcs_ok    = (calc == rcvd);
            end
        end
        restart_frame();
        return 1'b1;
    endfunction

    function automatic int pick_gap(input bit burst);
        int r;
        if (burst)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        else if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    task automatic report_fail(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("%s", what);
        end
    endtask

    task automatic send_byte(input logic [7:0] d, input logic last, input bit burst,
                             input bit use_typed, input fcs_result_t typed_res);
        int          gap;
        bit          has;
        fcs_result_t res;
        gap = pick_gap(burst);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        has = fcs_model_byte(d, last, res);
        if (has)
        begin
            pending_results.push_back(use_typed ? typed_res : res);
        end
        items_sent++;
        @(negedge clk);
    endtask

    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_results.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_mode(input check_mode_t m);
        settle_block();
        cfg_wr_en  <= 1'b1;
        check_mode <= m;
        @(negedge clk);
        cfg_wr_en  <= 1'b0;
        mode_shadow = m;
        restart_frame();
    endtask

    task automatic send_frame(input bit closed);
        bit burst;
        burst = ($urandom_range(0, 5) == 0);
        foreach (frame_buf[i])
        begin
            send_byte(frame_buf[i], closed && (i == frame_buf.size() - 1), burst, 1'b0, '0);
        end
    endtask

    task automatic fill_random(input int n);
        repeat (n) frame_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic build_frame(input check_mode_t m);
        int          r;
        int          idx;
        logic [31:0] c;
        frame_buf.delete();
        r = $urandom_range(0, 99);
        if (m == MODE_COMPUTE)
        begin
            fill_random(($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12));
        end
        else if (r < 85)
        begin
            // payload followed by its fcs, corrupted in one bit now and then
            fill_random(($urandom_range(0, 9) == 0) ? $urandom_range(16, 60)
                                                     : $urandom_range(0, 12));
            c = CRC_INIT;
            foreach (frame_buf[i])
            begin
                c = crc32_fold(c, frame_buf[i]);
            end
            c = c ^ CRC_INIT;
            frame_buf.push_back(c[7:0]);
            frame_buf.push_back(c[15:8]);
            frame_buf.push_back(c[23:16]);
            frame_buf.push_back(c[31:24]);
            if (r >= 70)
            begin
                idx = $urandom_range(0, frame_buf.size() - 1);
                frame_buf[idx] = frame_buf[idx] ^ (8'h01 << $urandom_range(0, 7));
            end
        end
        else if (r < 93)
        begin
            fill_random($urandom_range(1, 3));
        end
        else
        begin
            fill_random($urandom_range(4, 20));
        end
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int r;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                begin
                    m_axis_tready <= 1'b1;
                    repeat ($urandom_range(1, 20)) @(negedge clk);
                end
                else if (r < 95)
                begin
                    m_axis_tready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(negedge clk);
                end
                else
                begin
                    m_axis_tready <= 1'b0;
                    repeat ($urandom_range(10, 40)) @(negedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        fcs_result_t got;
        fcs_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.crc_value = m_axis_tdata;
            got.fcs_ok    = m_axis_tuser[0];
            got.too_short = m_axis_tuser[1];
            if (pending_results.size() == 0)
            begin
                report_fail($sformatf("unexpected result: crc %h ok %b short %b",
                                      got.crc_value, got.fcs_ok, got.too_short));
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.crc_value !== want.crc_value || got.fcs_ok !== want.fcs_ok
                    || got.too_short !== want.too_short)
                begin
                    report_fail($sformatf(
                        "result mismatch: crc %h/%h ok %b/%b short %b/%b (expected/actual)",
                        want.crc_value, got.crc_value, want.fcs_ok, got.fcs_ok,
                        want.too_short, got.too_short));
                end
            end
        end
    end

    initial
    begin
        int          phase;
        int          n;
        int unsigned random_start;
        check_mode_t m;
        restart_frame();
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (DIRECTED[i])
        begin
            if (DIRECTED[i].is_cfg)
            begin
                write_mode(DIRECTED[i].cfg_mode);
            end
            else
            begin
                send_byte(DIRECTED[i].data_byte, DIRECTED[i].frame_end, 1'b0,
                          DIRECTED[i].typed, DIRECTED[i].want);
            end
        end

        phase = 0;
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            if (phase == 0 || phase == 2)
            begin
                m = MODE_COMPUTE;
            end
            else if (phase == 1)
            begin
                m = MODE_VALIDATE;
            end
            else
            begin
                m = check_mode_t'($urandom_range(0, 1));
            end
            write_mode(m);
            // short frames against a stalled receiver back the block up
            if (phase == 2)
            begin
                hold_req = 1'b1;
                n = 24;
            end
            else
            begin
                n = $urandom_range(3, 12);
            end
            repeat (n)
            begin
                if (phase == 2)
                begin
                    frame_buf.delete();
                    fill_random($urandom_range(1, 2));
                end
                else
                begin
                    build_frame(m);
                end
                send_frame(1'b1);
            end
            if ($urandom_range(0, 9) < 3)
            begin
                frame_buf.delete();
                fill_random($urandom_range(1, 6));
                send_frame(1'b0);
            end
            phase++;
        end

        settle_block();
        if (mismatch_count == 0 && pending_results.size() == 0)
        begin
            $display("testbench OK");
        end
        else
        begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/fcschk_pkg.sv
rtl/core/fcschk_in_stage.sv
rtl/core/fcschk_engine.sv
rtl/core/fcschk_out_stage.sv
rtl/core/wifi_fcs_crc32_checker.sv
dv/testbench.sv
